[hdl/mfde_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types, constants and the 5x7 font for the framebuffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

   localparam int ScreenWidth  = 300;
   localparam int ScreenHeight = 400;
   localparam int RowBlocks    = (ScreenHeight + 3) / 4;
   localparam int ColPairs     = (ScreenWidth + 1) / 2;
   localparam int StoreBytes   = ColPairs * RowBlocks;
   localparam int AddrW        = $clog2(StoreBytes);

   // request codes
   localparam logic [2:0] REQ_PIXEL   = 3'd0;
   localparam logic [2:0] REQ_OUTLINE = 3'd1;
   localparam logic [2:0] REQ_FILL    = 3'd2;
   localparam logic [2:0] REQ_GLYPH   = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;
   localparam logic [2:0] REQ_READ    = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOX_LOAD,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_PIX_NEXT,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_READ_DONE,
      ST_RESP
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic latch_req;    // capture request fields
      logic box_start;    // load the walker for the current box
      logic pix_read;     // issue store read for current pixel
      logic pix_write;    // write modified byte
      logic walk_step;    // advance the walker
      logic clr_write;    // write clear byte at sweep index
      logic read_issue;   // issue read for read request
      logic read_cap;     // capture read data
      logic rsp_load;     // load response register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic box_empty;    // current box draws nothing
      logic walk_last;    // walker at last pixel of box
      logic box_last;     // no more boxes for this request
      logic clr_last;     // sweep at last byte
   } stat_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [9:0]  rect_w;
      logic [9:0]  rect_h;
      logic [7:0]  char_code;
      logic [3:0]  glyph_scale;
      logic        ink_black;
      logic [13:0] read_index;
   } req_type_t_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       op_done;
   } rsp_payload_type;

   // font slot lookup, lower case folded to upper case, unknown -> space
   function automatic logic [5:0] font_slot(input logic [7:0] code);
      logic [7:0] c;
      logic [5:0] k;
      c = (code >= 8'h61 && code <= 8'h7a) ? code - 8'd32 : code;
      unique case (c)
         8'h25: k = 6'd1;  8'h2d: k = 6'd2;  8'h2e: k = 6'd3;  8'h2f: k = 6'd4;
         8'h30: k = 6'd5;  8'h31: k = 6'd6;  8'h32: k = 6'd7;  8'h33: k = 6'd8;
         8'h34: k = 6'd9;  8'h35: k = 6'd10; 8'h36: k = 6'd11; 8'h37: k = 6'd12;
         8'h38: k = 6'd13; 8'h39: k = 6'd14; 8'h3a: k = 6'd15; 8'h41: k = 6'd16;
         8'h43: k = 6'd17; 8'h44: k = 6'd18; 8'h45: k = 6'd19; 8'h46: k = 6'd20;
         8'h47: k = 6'd21; 8'h48: k = 6'd22; 8'h49: k = 6'd23; 8'h4b: k = 6'd24;
         8'h4c: k = 6'd25; 8'h4d: k = 6'd26; 8'h4e: k = 6'd27; 8'h4f: k = 6'd28;
         8'h50: k = 6'd29; 8'h52: k = 6'd30; 8'h53: k = 6'd31; 8'h54: k = 6'd32;
         8'h55: k = 6'd33; 8'h57: k = 6'd34; 8'h58: k = 6'd35; 8'h59: k = 6'd36;
         default: k = 6'd0;
      endcase
      return k;
   endfunction

   // one 35-bit glyph, row 0 in bits [34:30], col 0 the MSB of each row
   function automatic logic [34:0] font_bits(input logic [5:0] k);
      logic [34:0] g;
      unique case (k)
         6'd1:  g = {5'h19,5'h19,5'h02,5'h04,5'h08,5'h13,5'h13};
         6'd2:  g = {5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00};
         6'd3:  g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0c,5'h0c};
         6'd4:  g = {5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00};
         6'd5:  g = {5'h0e,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0e};
         6'd6:  g = {5'h04,5'h0c,5'h04,5'h04,5'h04,5'h04,5'h0e};
         6'd7:  g = {5'h0e,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1f};
         6'd8:  g = {5'h1e,5'h01,5'h01,5'h0e,5'h01,5'h01,5'h1e};
         6'd9:  g = {5'h02,5'h06,5'h0a,5'h12,5'h1f,5'h02,5'h02};
         6'd10: g = {5'h1f,5'h10,5'h10,5'h1e,5'h01,5'h01,5'h1e};
         6'd11: g = {5'h06,5'h08,5'h10,5'h1e,5'h11,5'h11,5'h0e};
         6'd12: g = {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
         6'd13: g = {5'h0e,5'h11,5'h11,5'h0e,5'h11,5'h11,5'h0e};
         6'd14: g = {5'h0e,5'h11,5'h11,5'h0f,5'h01,5'h02,5'h0c};
         6'd15: g = {5'h00,5'h0c,5'h0c,5'h00,5'h0c,5'h0c,5'h00};
         6'd16: g = {5'h0e,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11};
         6'd17: g = {5'h0e,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0e};
         6'd18: g = {5'h1c,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1c};
         6'd19: g = {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h1f};
         6'd20: g = {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h10};
         6'd21: g = {5'h0e,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0f};
         6'd22: g = {5'h11,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11};
         6'd23: g = {5'h0e,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0e};
         6'd24: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
         6'd25: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1f};
         6'd26: g = {5'h11,5'h1b,5'h15,5'h15,5'h11,5'h11,5'h11};
         6'd27: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
         6'd28: g = {5'h0e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e};
         6'd29: g = {5'h1e,5'h11,5'h11,5'h1e,5'h10,5'h10,5'h10};
         6'd30: g = {5'h1e,5'h11,5'h11,5'h1e,5'h14,5'h12,5'h11};
         6'd31: g = {5'h0f,5'h10,5'h10,5'h0e,5'h01,5'h01,5'h1e};
         6'd32: g = {5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
         6'd33: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e};
         6'd34: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0a};
         6'd35: g = {5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11};
         6'd36: g = {5'h11,5'h11,5'h0a,5'h04,5'h04,5'h04,5'h04};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

[hdl/mfde_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_req_if / mfde_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface mfde_req_if;
   logic                     valid;
   logic                     ready;
   mfde_pkg::req_type_t_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mfde_rsp_if;
   logic                      valid;
   logic                      ready;
   mfde_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/mfde_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mfde_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output      logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

[hdl/mfde_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_ctrl
// Request sequencer: walks boxes pixel by pixel, sweeps clears, reads.
// ----------------------------------------------------------------------------
module mfde_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [2:0]         req_kind,
   input  wire logic               rsp_busy,
   input  wire mfde_pkg::stat_type stat,
   output      logic               req_ready,
   output      mfde_pkg::cmd_type  cmd
);
   mfde_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfde_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfde_pkg::ST_IDLE: begin
            if (req_valid && !rsp_busy) begin
               priority case (req_kind)
                  mfde_pkg::REQ_PIXEL, mfde_pkg::REQ_OUTLINE,
                  mfde_pkg::REQ_FILL, mfde_pkg::REQ_GLYPH:
                     state_in = mfde_pkg::ST_BOX_LOAD;
                  mfde_pkg::REQ_CLEAR: state_in = mfde_pkg::ST_CLEAR;
                  mfde_pkg::REQ_READ:  state_in = mfde_pkg::ST_READ_WAIT;
                  default:             state_in = mfde_pkg::ST_RESP;
               endcase
            end
         end
         mfde_pkg::ST_BOX_LOAD: begin
            if (stat.box_empty) begin
               state_in = stat.box_last ? mfde_pkg::ST_RESP : mfde_pkg::ST_BOX_LOAD;
            end else begin
               state_in = mfde_pkg::ST_PIX_RD;
            end
         end
         mfde_pkg::ST_PIX_RD: state_in = mfde_pkg::ST_PIX_WR;
         mfde_pkg::ST_PIX_WR: state_in = mfde_pkg::ST_PIX_NEXT;
         mfde_pkg::ST_PIX_NEXT: begin
            if (!stat.walk_last) begin
               state_in = mfde_pkg::ST_PIX_RD;
            end else if (stat.box_last) begin
               state_in = mfde_pkg::ST_RESP;
            end else begin
               state_in = mfde_pkg::ST_BOX_LOAD;
            end
         end
         mfde_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = mfde_pkg::ST_RESP;
         end
         mfde_pkg::ST_READ_WAIT: state_in = mfde_pkg::ST_READ_DONE;
         mfde_pkg::ST_READ_DONE: state_in = mfde_pkg::ST_RESP;
         mfde_pkg::ST_RESP:      state_in = mfde_pkg::ST_IDLE;
         default:                state_in = mfde_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mfde_pkg::ST_IDLE: begin
            req_ready     = !rsp_busy;
            cmd.latch_req = req_valid && !rsp_busy;
         end
         mfde_pkg::ST_BOX_LOAD:  cmd.box_start  = 1'b1;
         mfde_pkg::ST_PIX_RD:    cmd.pix_read   = 1'b1;
         mfde_pkg::ST_PIX_WR:    cmd.pix_write  = 1'b1;
         mfde_pkg::ST_PIX_NEXT:  cmd.walk_step  = 1'b1;
         mfde_pkg::ST_CLEAR:     cmd.clr_write  = 1'b1;
         mfde_pkg::ST_READ_WAIT: cmd.read_issue = 1'b1;
         mfde_pkg::ST_READ_DONE: cmd.read_cap   = 1'b1;
         mfde_pkg::ST_RESP:      cmd.rsp_load   = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

[hdl/mfde_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_dpath
// Box generator, pixel walker, address math and frame store.
// ----------------------------------------------------------------------------
module mfde_dpath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mfde_pkg::req_type_t_type   req,
   input  wire mfde_pkg::cmd_type          cmd,
   output      mfde_pkg::stat_type         stat,
   output      logic [7:0]                 read_data
);
   localparam int CW = 14;  // walker coordinate width, covers x + 15*4 + 15
   localparam int AW = mfde_pkg::AddrW;

   mfde_pkg::req_type_t_type r_ff;
   logic [34:0] glyph_ff;
   // box index: outline uses 0..3, glyph 0..34
   logic [5:0]  box_ff, box_in;
   logic signed [CW-1:0] bx_ff, by_ff;        // box origin
   logic [10:0] bw_ff, bh_ff;                 // box size
   logic [10:0] wi_ff, wj_ff;                 // walker offsets
   logic        box_empty_c;
   logic signed [CW-1:0] bx_c, by_c;
   logic [10:0] bw_c, bh_c;
   logic        box_last_c;
   logic [2:0]  grow_c;
   logic [2:0]  gcol_c;
   logic [AW-1:0] clr_ff;

   // pixel address pipeline
   logic signed [CW-1:0] px_c, py_c;
   logic        pin_c;
   logic [10:0] rr_c, cc_c;
   logic [AW-1:0] pa_ff;
   logic [2:0]  pbit_ff;
   logic        pv_ff;
   logic [19:0] prod_c;

   // ram port
   logic          we;
   logic [AW-1:0] addr;
   logic [7:0]    wdata, rdata;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         r_ff     <= req;
         glyph_ff <= mfde_pkg::font_bits(mfde_pkg::font_slot(req.char_code));
      end
   end

   // box geometry for current box index
   always_comb begin
      // row = index / 5 by reciprocal multiply, exact over 0..34
      grow_c = 3'((12'(box_ff) * 12'd52) >> 8);
      gcol_c = 3'(box_ff - 6'(grow_c) * 6'd5);
      bx_c = CW'(r_ff.pos_x);
      by_c = CW'(r_ff.pos_y);
      bw_c = 11'(r_ff.rect_w);
      bh_c = 11'(r_ff.rect_h);
      box_empty_c = (r_ff.rect_w == '0) || (r_ff.rect_h == '0);
      box_last_c = 1'b1;
      priority case (r_ff.req_type)
         mfde_pkg::REQ_PIXEL: begin
            bw_c = 11'd1; bh_c = 11'd1; box_empty_c = 1'b0;
         end
         mfde_pkg::REQ_OUTLINE: begin
            box_last_c = (box_ff == 6'd3);
            unique case (box_ff[1:0])
               2'd0: bh_c = 11'd1;
               2'd1: begin by_c = by_c + CW'(r_ff.rect_h) - CW'(1); bh_c = 11'd1; end
               2'd2: bw_c = 11'd1;
               default: begin bx_c = bx_c + CW'(r_ff.rect_w) - CW'(1); bw_c = 11'd1; end
            endcase
         end
         mfde_pkg::REQ_GLYPH: begin
            box_last_c = (box_ff == 6'd34);
            bx_c = bx_c + CW'(gcol_c) * CW'(r_ff.glyph_scale);
            by_c = by_c + CW'(grow_c) * CW'(r_ff.glyph_scale);
            bw_c = 11'(r_ff.glyph_scale);
            bh_c = 11'(r_ff.glyph_scale);
            box_empty_c = (r_ff.glyph_scale == '0) || !glyph_ff[6'd34 - box_ff];
         end
         default: ;
      endcase
   end

   // box counter and walker
   always_comb begin
      box_in = box_ff;
      if (cmd.latch_req) begin
         box_in = '0;
      end else if (cmd.box_start && box_empty_c) begin
         box_in = box_ff + 6'd1;
      end else if (cmd.walk_step && stat.walk_last) begin
         box_in = box_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else begin
         box_ff <= box_in;
      end
      if (cmd.box_start) begin
         bx_ff <= bx_c;  by_ff <= by_c;
         bw_ff <= bw_c;  bh_ff <= bh_c;
         wi_ff <= '0;    wj_ff <= '0;
      end else if (cmd.walk_step) begin
         if (wi_ff == bw_ff - 11'd1) begin
            wi_ff <= '0;
            wj_ff <= wj_ff + 11'd1;
         end else begin
            wi_ff <= wi_ff + 11'd1;
         end
      end
   end

   assign stat.box_empty = box_empty_c;
   assign stat.box_last  = box_last_c;
   assign stat.walk_last = (wi_ff == bw_ff - 11'd1) && (wj_ff == bh_ff - 11'd1);
   assign stat.clr_last  = (clr_ff == AW'(mfde_pkg::StoreBytes - 1));

   // clip and map current pixel to byte address
   always_comb begin
      px_c  = bx_ff + CW'(wi_ff);
      py_c  = by_ff + CW'(wj_ff);
      pin_c = (px_c >= 0) && (py_c >= 0) &&
              (px_c < CW'(mfde_pkg::ScreenWidth)) && (py_c < CW'(mfde_pkg::ScreenHeight));
      rr_c  = 11'(CW'(mfde_pkg::ScreenHeight - 1) - py_c);
      cc_c  = 11'(px_c);
      prod_c = 20'(cc_c[10:1]) * 20'(mfde_pkg::RowBlocks) + 20'(rr_c[10:2]);
   end

   always_ff @(posedge clock) begin
      if (cmd.box_start || cmd.walk_step) begin
         pv_ff <= 1'b0;
      end else if (cmd.pix_read) begin
         pv_ff <= pin_c;
      end
      if (cmd.pix_read) begin
         pa_ff   <= AW'(prod_c);
         pbit_ff <= 3'd7 - {rr_c[1:0], cc_c[0]};
      end
   end

   // clear sweep index
   always_ff @(posedge clock) begin
      if (reset || cmd.latch_req) begin
         clr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // store port
   always_comb begin
      we    = 1'b0;
      addr  = pa_ff;
      wdata = rdata;
      priority if (cmd.clr_write) begin
         we    = 1'b1;
         addr  = clr_ff;
         wdata = r_ff.ink_black ? 8'h00 : 8'hFF;
      end else if (cmd.pix_read) begin
         addr = AW'(prod_c);
      end else if (cmd.pix_write) begin
         we = pv_ff;
         wdata = r_ff.ink_black ? (rdata & ~(8'h01 << pbit_ff))
                                : (rdata | (8'h01 << pbit_ff));
      end else if (cmd.read_issue) begin
         addr = r_ff.read_index[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         read_data <= '0;
      end else if (cmd.read_cap &&
                   (r_ff.read_index < 14'(mfde_pkg::StoreBytes))) begin
         read_data <= rdata;
      end
   end

   mfde_ram #(.Width(8), .Depth(mfde_pkg::StoreBytes)) u_store (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );
endmodule
`default_nettype wire

[hdl/mono_framebuffer_draw_engine_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_unit
// Drawing engine over a 1-bit packed monochrome framebuffer.
// ----------------------------------------------------------------------------
// One request at a time. Each drawn pixel passes through a store read, a
// read-modify-write and a walker step on the single frame store port, plus
// a box load per rectangle part or glyph dot; a clear sweeps the store one byte
// per cycle across all 15000 bytes. The store has no reset value: clear it
// before drawing or reading.
// The response is registered, so a new request is taken as soon as the
// previous response has left the output register.
module mono_framebuffer_draw_engine_unit (
   input wire logic  clock,
   input wire logic  reset,
   mfde_req_if.sink   req_ch,
   mfde_rsp_if.source rsp_ch
);
   mfde_pkg::cmd_type  cmd;
   mfde_pkg::stat_type stat;
   logic               rsp_valid_ff;
   logic [7:0]         read_data;

   mfde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.data.req_type),
      .rsp_busy  (rsp_valid_ff),
      .stat      (stat),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   mfde_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.data),
      .cmd       (cmd),
      .stat      (stat),
      .read_data (read_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.data.read_data = read_data;
   assign rsp_ch.data.op_done   = 1'b1;

   // no request is accepted while a response is pending
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(req_ch.valid && req_ch.ready))
      else $error("request accepted while response pending");

   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("response not raised after load");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.pix_read, cmd.pix_write, cmd.clr_write, cmd.read_issue}))
      else $error("conflicting store commands");
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the monochrome framebuffer draw engine. A local
// shadow of the frame store predicts every response. Read-back requests are
// mostly aimed at or near the pixels that were just drawn, so draws are checked
// through the store bytes they changed.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IdleLimit = 200000;
   localparam int FontCount = 37;
   localparam logic [2:0] REQ_BAD_A = 3'd6;
   localparam logic [2:0] REQ_BAD_B = 3'd7;

   logic clock;
   logic reset;

   mfde_req_if req_ch ();
   mfde_rsp_if rsp_ch ();

   mono_framebuffer_draw_engine_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // shadow frame store and font
   logic [7:0] shadow_frame [mfde_pkg::StoreBytes];
   byte unsigned glyph_code [FontCount] = '{
      8'h20, 8'h25, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h41, 8'h43, 8'h44, 8'h45,
      8'h46, 8'h47, 8'h48, 8'h49, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50,
      8'h52, 8'h53, 8'h54, 8'h55, 8'h57, 8'h58, 8'h59};
   logic [4:0] glyph_row [FontCount][7] = '{
      '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
      '{5'h19,5'h19,5'h02,5'h04,5'h08,5'h13,5'h13},
      '{5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00},
      '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0c,5'h0c},
      '{5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00},
      '{5'h0e,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0e},
      '{5'h04,5'h0c,5'h04,5'h04,5'h04,5'h04,5'h0e},
      '{5'h0e,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1f},
      '{5'h1e,5'h01,5'h01,5'h0e,5'h01,5'h01,5'h1e},
      '{5'h02,5'h06,5'h0a,5'h12,5'h1f,5'h02,5'h02},
      '{5'h1f,5'h10,5'h10,5'h1e,5'h01,5'h01,5'h1e},
      '{5'h06,5'h08,5'h10,5'h1e,5'h11,5'h11,5'h0e},
      '{5'h1f,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
      '{5'h0e,5'h11,5'h11,5'h0e,5'h11,5'h11,5'h0e},
      '{5'h0e,5'h11,5'h11,5'h0f,5'h01,5'h02,5'h0c},
      '{5'h00,5'h0c,5'h0c,5'h00,5'h0c,5'h0c,5'h00},
      '{5'h0e,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11},
      '{5'h0e,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0e},
      '{5'h1c,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1c},
      '{5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h1f},
      '{5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h10},
      '{5'h0e,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0f},
      '{5'h11,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11},
      '{5'h0e,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0e},
      '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
      '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1f},
      '{5'h11,5'h1b,5'h15,5'h15,5'h11,5'h11,5'h11},
      '{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
      '{5'h0e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e},
      '{5'h1e,5'h11,5'h11,5'h1e,5'h10,5'h10,5'h10},
      '{5'h1e,5'h11,5'h11,5'h1e,5'h14,5'h12,5'h11},
      '{5'h0f,5'h10,5'h10,5'h0e,5'h01,5'h01,5'h1e},
      '{5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
      '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e},
      '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0a},
      '{5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11},
      '{5'h11,5'h11,5'h0a,5'h04,5'h04,5'h04,5'h04}};

   mfde_pkg::rsp_payload_type expected_rsp_q [$];
   int  mismatch_count;
   int  requests_sent;
   int  responses_checked;
   int  reads_sent;
   int  idle_cycles;
   bit  no_idle;
   int  last_x;
   int  last_y;

   // clock and reset
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow frame store model
   // ------------------------------------------------------------------
   function automatic int byte_of(int x, int y);
      int r;
      r = mfde_pkg::ScreenHeight - 1 - y;
      return (x >> 1) * mfde_pkg::RowBlocks + (r >> 2);
   endfunction

   function automatic void plot(int x, int y, bit black);
      int r;
      int idx;
      int bitpos;
      if (x < 0 || y < 0 || x >= mfde_pkg::ScreenWidth || y >= mfde_pkg::ScreenHeight)
         return;
      r      = mfde_pkg::ScreenHeight - 1 - y;
      idx    = byte_of(x, y);
      bitpos = 7 - (((r & 3) << 1) | (x & 1));
      shadow_frame[idx][bitpos] = ~black;
   endfunction

   function automatic void fill_area(int x, int y, int w, int h, bit black);
      for (int j = 0; j < h; j++)
         for (int i = 0; i < w; i++)
            plot(x + i, y + j, black);
   endfunction

   function automatic void draw_outline(int x, int y, int w, int h, bit black);
      if (w == 0 || h == 0) return;
      for (int i = 0; i < w; i++) begin
         plot(x + i, y, black);
         plot(x + i, y + h - 1, black);
      end
      for (int j = 0; j < h; j++) begin
         plot(x, y + j, black);
         plot(x + w - 1, y + j, black);
      end
   endfunction

   function automatic int glyph_index(byte unsigned code);
      byte unsigned c;
      c = (code >= 8'h61 && code <= 8'h7a) ? code - 8'd32 : code;
      for (int k = 0; k < FontCount; k++)
         if (glyph_code[k] == c) return k;
      return 0;
   endfunction

   // apply one request to the shadow store and return its response
   function automatic mfde_pkg::rsp_payload_type predict_response(
      mfde_pkg::req_type_t_type rq);
      mfde_pkg::rsp_payload_type rs;
      int x;
      int y;
      int s;
      int k;
      x  = $signed(rq.pos_x);
      y  = $signed(rq.pos_y);
      s  = rq.glyph_scale;
      rs = '0;
      rs.op_done = 1'b1;
      case (rq.req_type)
         mfde_pkg::REQ_PIXEL:   plot(x, y, rq.ink_black);
         mfde_pkg::REQ_OUTLINE: draw_outline(x, y, rq.rect_w, rq.rect_h, rq.ink_black);
         mfde_pkg::REQ_FILL:    fill_area(x, y, rq.rect_w, rq.rect_h, rq.ink_black);
         mfde_pkg::REQ_GLYPH: begin
            k = glyph_index(rq.char_code);
            for (int row = 0; row < 7; row++)
               for (int col = 0; col < 5; col++)
                  if (glyph_row[k][row][4 - col])
                     fill_area(x + col * s, y + row * s, s, s, rq.ink_black);
         end
         mfde_pkg::REQ_CLEAR: begin
            for (int i = 0; i < mfde_pkg::StoreBytes; i++)
               shadow_frame[i] = rq.ink_black ? 8'h00 : 8'hFF;
         end
         mfde_pkg::REQ_READ: begin
            if (rq.read_index < mfde_pkg::StoreBytes)
               rs.read_data = shadow_frame[rq.read_index];
         end
         default: ;
      endcase
      return rs;
   endfunction

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------
   task automatic send_request(input mfde_pkg::req_type_t_type item);
      int gap;
      if (!no_idle && $urandom_range(99) < 15) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsp_q.push_back(predict_response(item));
      requests_sent++;
      if (item.req_type == mfde_pkg::REQ_READ) reads_sent++;
   endtask

   function automatic mfde_pkg::req_type_t_type make_req(logic [2:0] kind, int x, int y,
                                                         int w, int h, int code,
                                                         int scale, bit ink, int idx);
      mfde_pkg::req_type_t_type rq;
      rq.req_type    = kind;
      rq.pos_x       = x[11:0];
      rq.pos_y       = y[11:0];
      rq.rect_w      = w[9:0];
      rq.rect_h      = h[9:0];
      rq.char_code   = code[7:0];
      rq.glyph_scale = scale[3:0];
      rq.ink_black   = ink;
      rq.read_index  = idx[13:0];
      return rq;
   endfunction

   // read back the byte under a pixel
   task automatic read_pixel(int x, int y);
      send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, byte_of(x, y)));
   endtask

   // ------------------------------------------------------------------
   // Response side: random backpressure, checker, watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else       rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
   end

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      mfde_pkg::rsp_payload_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_ch.data.read_data !== exp_rsp.read_data)
               report_mismatch($sformatf("read_data got %02h want %02h",
                                         rsp_ch.data.read_data, exp_rsp.read_data));
            if (rsp_ch.data.op_done !== exp_rsp.op_done)
               report_mismatch($sformatf("op_done got %b want %b",
                                         rsp_ch.data.op_done, exp_rsp.op_done));
            responses_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no transaction for %0d cycles", IdleLimit);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------
   task automatic test_clear_and_read();
      send_request(make_req(mfde_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0,
                            mfde_pkg::StoreBytes - 1));
      send_request(make_req(mfde_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
      // index past the store end and the top index value
      send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0,
                            mfde_pkg::StoreBytes));
      send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 16383));
   endtask

   task automatic test_pixels();
      send_request(make_req(mfde_pkg::REQ_PIXEL, 0, 0, 0, 0, 0, 0, 1, 0));
      read_pixel(0, 0);
      send_request(make_req(mfde_pkg::REQ_PIXEL, mfde_pkg::ScreenWidth - 1,
                            mfde_pkg::ScreenHeight - 1, 0, 0, 0, 0, 1, 0));
      read_pixel(mfde_pkg::ScreenWidth - 1, mfde_pkg::ScreenHeight - 1);
      // clipped at negative x, and at large x with negative y
      send_request(make_req(mfde_pkg::REQ_PIXEL, -1, 5, 0, 0, 0, 0, 1, 0));
      send_request(make_req(mfde_pkg::REQ_PIXEL, 2047, -2048, 0, 0, 0, 0, 1, 0));
   endtask

   task automatic test_rects();
      send_request(make_req(mfde_pkg::REQ_FILL, -3, -2, 7, 6, 0, 0, 1, 0));
      read_pixel(1, 1);
      send_request(make_req(mfde_pkg::REQ_OUTLINE, 290, 390, 20, 20, 0, 0, 1, 0));
      read_pixel(290, 395);
      // zero sizes draw nothing; full widths clip
      send_request(make_req(mfde_pkg::REQ_FILL, 10, 10, 0, 5, 0, 0, 1, 0));
      send_request(make_req(mfde_pkg::REQ_OUTLINE, 10, 10, 5, 0, 0, 0, 1, 0));
      send_request(make_req(mfde_pkg::REQ_OUTLINE, -100, 200, 1023, 1023, 0, 0, 1, 0));
      read_pixel(150, 200);
   endtask

   task automatic test_glyphs();
      send_request(make_req(mfde_pkg::REQ_GLYPH, 20, 20, 0, 0, 8'h61, 2, 1, 0));
      read_pixel(22, 24);
      send_request(make_req(mfde_pkg::REQ_GLYPH, 40, 20, 0, 0, 8'hFF, 3, 1, 0));
      send_request(make_req(mfde_pkg::REQ_GLYPH, 60, 20, 0, 0, 8'h4D, 0, 1, 0));
      send_request(make_req(mfde_pkg::REQ_GLYPH, 250, 340, 0, 0, 8'h25, 15, 1, 0));
      read_pixel(260, 350);
      send_request(make_req(REQ_BAD_A, 0, 0, 0, 0, 0, 0, 1, 0));
      send_request(make_req(REQ_BAD_B, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // ------------------------------------------------------------------
   // Random mix, reads aimed mostly at the last drawn spot
   // ------------------------------------------------------------------
   task automatic test_random(input int count);
      mfde_pkg::req_type_t_type rq;
      int pick;
      int x;
      int y;
      for (int n = 0; n < count; n++) begin
         no_idle = (n >= 500 && n < 800);
         rq = make_req(mfde_pkg::REQ_PIXEL, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
         if ($urandom_range(99) < 95) begin
            rq.pos_x = 12'($urandom_range(0, mfde_pkg::ScreenWidth + 40) - 20);
            rq.pos_y = 12'($urandom_range(0, mfde_pkg::ScreenHeight + 40) - 20);
         end
         pick = $urandom_range(999);
         if (pick < 350) begin
            rq.req_type = mfde_pkg::REQ_READ;
            if ($urandom_range(99) < 75) begin
               x = last_x + $urandom_range(0, 12);
               y = last_y + $urandom_range(0, 12);
               if (x >= mfde_pkg::ScreenWidth)  x = mfde_pkg::ScreenWidth - 1;
               if (y >= mfde_pkg::ScreenHeight) y = mfde_pkg::ScreenHeight - 1;
               rq.read_index = 14'(byte_of(x, y));
            end
         end else if (pick < 550) begin
            rq.req_type = mfde_pkg::REQ_PIXEL;
         end else if (pick < 690) begin
            rq.req_type = mfde_pkg::REQ_FILL;
            rq.rect_w = 10'($urandom_range(0, 20));
            rq.rect_h = 10'($urandom_range(0, 20));
            if ($urandom_range(99) < 4) rq.rect_w = 10'($urandom);
         end else if (pick < 810) begin
            rq.req_type = mfde_pkg::REQ_OUTLINE;
            rq.rect_w = 10'($urandom_range(0, 30));
            rq.rect_h = 10'($urandom_range(0, 30));
            if ($urandom_range(99) < 4) begin
               rq.rect_w = 10'($urandom);
               rq.rect_h = 10'($urandom);
            end
         end else if (pick < 950) begin
            rq.req_type = mfde_pkg::REQ_GLYPH;
            rq.glyph_scale = 4'($urandom_range(0, 3));
            if ($urandom_range(99) < 4) rq.glyph_scale = 4'($urandom);
            if ($urandom_range(99) < 70) begin
               rq.char_code = glyph_code[$urandom_range(0, FontCount - 1)];
               if (rq.char_code >= 8'h41 && $urandom_range(1)) rq.char_code += 8'd32;
            end
         end else if (pick < 958) begin
            rq.req_type = mfde_pkg::REQ_CLEAR;
         end else begin
            rq.req_type = $urandom_range(1) ? REQ_BAD_A : REQ_BAD_B;
         end
         if (rq.req_type != mfde_pkg::REQ_READ) begin
            last_x = $signed(rq.pos_x);
            last_y = $signed(rq.pos_y);
            if (last_x < 0 || last_x >= mfde_pkg::ScreenWidth)
               last_x = $urandom_range(0, 290);
            if (last_y < 0 || last_y >= mfde_pkg::ScreenHeight)
               last_y = $urandom_range(0, 390);
         end
         send_request(rq);
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      mismatch_count    = 0;
      requests_sent     = 0;
      responses_checked = 0;
      reads_sent        = 0;
      no_idle           = 1'b0;
      last_x            = 0;
      last_y            = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_clear_and_read();
      test_pixels();
      test_rects();
      test_glyphs();
      test_random(1680);

      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("covered %0d requests (%0d read-backs), %0d responses checked",
               requests_sent, reads_sent, responses_checked);
      $display("draws, clips, zero sizes, folded and unknown glyphs, clears, bad codes");
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
